### sv/json_structure_prefilter_core_macros.svh
// Assertion macros shared by the checker of the JSON structure prefilter.
// Depends on nothing; included by the checker file only.
`ifndef JSON_STRUCTURE_PREFILTER_CORE_MACROS_SVH
`define JSON_STRUCTURE_PREFILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/jsp_pkg.sv
// Shared types, constants and the byte classifier of the JSON structure prefilter.
// Depends on nothing; the RTL and checker use scoped names, the testbench imports it.
package jsp_pkg;

  // Queue between the classifier and the scanner.
  localparam int unsigned QueueDepthDef = 4;

  // Configuration port.
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 5;
  localparam logic [CfgIndexW-1:0] CfgMaxDepth = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgMaxSpan  = 2'd1;

  localparam int unsigned DepthW = 4;
  localparam int unsigned SpanW  = 5;
  localparam logic [DepthW-1:0] MaxDepthRst = 4'd8;
  localparam logic [SpanW-1:0]  MaxSpanRst  = 5'd16;

  // Progress of the escaped u0000 matcher.
  localparam logic [2:0] NulIdle    = 3'd0;
  localparam logic [2:0] NulBslash  = 3'd1;
  localparam logic [2:0] NulAfterU  = 3'd2;
  localparam logic [2:0] NulAllZero = 3'd5;

  // ASCII codes the classifier looks for.
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChLowerU = 8'h75;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;

  typedef enum logic [2:0] {
    FailNone   = 3'd0,
    FailNul    = 3'd1,
    FailEscNul = 3'd2,
    FailEscEnd = 3'd3,
    FailNumber = 3'd4,
    FailDepth  = 3'd5,
    FailClose  = 3'd6
  } fail_code_e;

  typedef enum logic [1:0] {
    PhaseNone   = 2'd0,
    PhaseMinus  = 2'd1,
    PhaseDigits = 2'd2
  } number_phase_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic nul;
    logic digit;
    logic zero;
    logic lower_u;
    logic minus;
    logic quote;
    logic bslash;
    logic open;
    logic close;
    logic term;
    logic last;
  } byte_class_t;

  function automatic byte_class_t classify_byte(logic [7:0] b, logic last);
    byte_class_t c;
    c.nul     = (b == ChNul);
    c.digit   = (b >= ChZero) && (b <= ChNine);
    c.zero    = (b == ChZero);
    c.lower_u = (b == ChLowerU);
    c.minus   = (b == ChMinus);
    c.quote   = (b == ChQuote);
    c.bslash  = (b == ChBslash);
    c.open    = (b == ChLBrace) || (b == ChLBrack);
    c.close   = (b == ChRBrace) || (b == ChRBrack);
    c.term    = ((b >= ChTab) && (b <= ChCr)) || (b == ChSpace) || (b == ChComma) ||
                (b == ChRBrack) || (b == ChRBrace);
    c.last    = last;
    return c;
  endfunction

endpackage

### sv/jsp_front.sv
// Front end of the JSON structure prefilter: input handshake and byte classification.
// Depends on jsp_pkg.
module jsp_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         text_byte_i,
  input  logic               last_byte_i,
  input  logic               full_i,
  output logic               push_o,
  output jsp_pkg::byte_class_t ent_o
);

  // A byte is taken whenever the queue has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign ent_o      = jsp_pkg::classify_byte(text_byte_i, last_byte_i);

endmodule

### sv/jsp_queue.sv
// Short queue of classified bytes between the front end and the scanner.
// Depends on jsp_pkg.
module jsp_queue #(
  parameter int unsigned Depth = jsp_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jsp_pkg::byte_class_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output jsp_pkg::byte_class_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jsp_pkg::byte_class_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/jsp_back.sv
// Back end of the JSON structure prefilter: scan state, rule checks and result register.
// Depends on jsp_pkg.
module jsp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ent_valid_i,
  input  jsp_pkg::byte_class_t        ent_i,
  output logic                        ent_pop_o,
  input  logic [jsp_pkg::DepthW-1:0]  max_depth_i,
  input  logic [jsp_pkg::SpanW-1:0]   max_span_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic [2:0]                  fail_code_o
);

  logic                      in_string_q, in_string_d;
  logic                      esc_q, esc_d;
  logic [2:0]                nulp_q, nulp_d;
  logic [jsp_pkg::DepthW-1:0] depth_q, depth_d;
  jsp_pkg::number_phase_e    phase_q, phase_d;
  logic                      lz_q, lz_d;
  logic [jsp_pkg::SpanW-1:0] span_q, span_d;
  logic                      failed_q, failed_d;
  jsp_pkg::fail_code_e       first_q, first_d;
  logic                      halt;

  logic                      out_valid_q, out_valid_d;
  logic                      accepted_q, accepted_d;
  jsp_pkg::fail_code_e       code_q, code_d;

  // Ordinary bytes never produce a result; the last byte needs the result slot.
  assign ent_pop_o = ent_valid_i && (!ent_i.last || !out_valid_q || !out_stall_i);

  // Scan of one byte, followed by the end-of-text checks.
  always_comb begin
    in_string_d = in_string_q;
    esc_d       = esc_q;
    nulp_d      = nulp_q;
    depth_d     = depth_q;
    phase_d     = phase_q;
    lz_d        = lz_q;
    span_d      = span_q;
    failed_d    = failed_q;
    first_d     = first_q;
    halt        = 1'b0;

    if (!failed_q) begin
      if (esc_q) begin
        // The escaped byte only feeds the u0000 matcher.
        esc_d  = 1'b0;
        nulp_d = ent_i.lower_u ? jsp_pkg::NulAfterU : jsp_pkg::NulIdle;
        halt   = 1'b1;
      end
      if (!halt && (nulp_q >= jsp_pkg::NulAfterU)) begin
        if (ent_i.zero) begin
          if (nulp_q >= jsp_pkg::NulAllZero) begin
            failed_d = 1'b1;
            first_d  = jsp_pkg::FailEscNul;
            halt     = 1'b1;
          end else begin
            nulp_d = nulp_q + 3'd1;
          end
        end else begin
          nulp_d = jsp_pkg::NulIdle;
        end
      end
      if (!halt && (phase_q == jsp_pkg::PhaseMinus)) begin
        halt = 1'b1;
        if (ent_i.digit) begin
          phase_d = jsp_pkg::PhaseDigits;
          lz_d    = ent_i.zero;
          if (span_q >= max_span_i) begin
            failed_d = 1'b1;
            first_d  = jsp_pkg::FailNumber;
          end else begin
            span_d = span_q + 1'b1;
          end
        end else begin
          failed_d = 1'b1;
          first_d  = jsp_pkg::FailNumber;
        end
      end
      if (!halt && (phase_q == jsp_pkg::PhaseDigits)) begin
        if (ent_i.digit) begin
          halt = 1'b1;
          if (lz_q || (span_q >= max_span_i)) begin
            failed_d = 1'b1;
            first_d  = jsp_pkg::FailNumber;
          end else begin
            span_d = span_q + 1'b1;
          end
        end else if (!ent_i.term) begin
          halt     = 1'b1;
          failed_d = 1'b1;
          first_d  = jsp_pkg::FailNumber;
        end else begin
          // The terminator falls through and is handled as a plain byte.
          phase_d = jsp_pkg::PhaseNone;
          lz_d    = 1'b0;
          span_d  = '0;
        end
      end
      if (!halt) begin
        if (ent_i.nul) begin
          failed_d = 1'b1;
          first_d  = jsp_pkg::FailNul;
        end else if (in_string_q && ent_i.bslash) begin
          esc_d  = 1'b1;
          nulp_d = jsp_pkg::NulBslash;
        end else if (!in_string_q && (ent_i.minus || ent_i.digit)) begin
          span_d  = '0;
          phase_d = ent_i.minus ? jsp_pkg::PhaseMinus : jsp_pkg::PhaseDigits;
          lz_d    = ent_i.zero;
        end else if (ent_i.quote) begin
          in_string_d = !in_string_q;
        end else if (!in_string_q && ent_i.open) begin
          if (depth_q >= max_depth_i) begin
            failed_d = 1'b1;
            first_d  = jsp_pkg::FailDepth;
          end else begin
            depth_d = depth_q + 1'b1;
          end
        end else if (!in_string_q && ent_i.close) begin
          if (depth_q == '0) begin
            failed_d = 1'b1;
            first_d  = jsp_pkg::FailClose;
          end else begin
            depth_d = depth_q - 1'b1;
          end
        end
      end
    end

    if (ent_i.last && !failed_d) begin
      if (esc_d) begin
        failed_d = 1'b1;
        first_d  = jsp_pkg::FailEscEnd;
      end else if (phase_d == jsp_pkg::PhaseMinus) begin
        failed_d = 1'b1;
        first_d  = jsp_pkg::FailNumber;
      end
    end
  end

  // Result register: loaded on the last byte, held while stalled.
  always_comb begin
    out_valid_d = out_valid_q;
    accepted_d  = accepted_q;
    code_d      = code_q;
    if (ent_pop_o && ent_i.last) begin
      out_valid_d = 1'b1;
      accepted_d  = !failed_d;
      code_d      = failed_d ? first_d : jsp_pkg::FailNone;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      esc_q       <= 1'b0;
      nulp_q      <= jsp_pkg::NulIdle;
      depth_q     <= '0;
      phase_q     <= jsp_pkg::PhaseNone;
      lz_q        <= 1'b0;
      span_q      <= '0;
      failed_q    <= 1'b0;
      first_q     <= jsp_pkg::FailNone;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ent_pop_o) begin
        if (ent_i.last) begin
          in_string_q <= 1'b0;
          esc_q       <= 1'b0;
          nulp_q      <= jsp_pkg::NulIdle;
          depth_q     <= '0;
          phase_q     <= jsp_pkg::PhaseNone;
          lz_q        <= 1'b0;
          span_q      <= '0;
          failed_q    <= 1'b0;
          first_q     <= jsp_pkg::FailNone;
        end else begin
          in_string_q <= in_string_d;
          esc_q       <= esc_d;
          nulp_q      <= nulp_d;
          depth_q     <= depth_d;
          phase_q     <= phase_d;
          lz_q        <= lz_d;
          span_q      <= span_d;
          failed_q    <= failed_d;
          first_q     <= first_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    accepted_q <= accepted_d;
    code_q     <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign fail_code_o = code_q;

endmodule

### sv/json_structure_prefilter_core.sv
// Top level of the JSON structure prefilter: configuration registers and the
// front end, queue and scanner. Depends on jsp_pkg, jsp_front, jsp_queue, jsp_back.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   text_byte_i, last_byte_i
//   out      output     out_valid_o / out_stall_i accepted_o, fail_code_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The block takes one byte per cycle while the queue has room; the scanner retires one
// queued byte per cycle unless a last byte waits on a stalled result. After the last
// byte is transferred, its result passes the queue and then the result register.
// Reset clears the scan state, the queue and the result valid flag at once; there
// is no clearing pass. While the output stalls, ordinary bytes still retire and
// only a last byte waits, so the input stalls only once QueueDepth bytes are queued.
module json_structure_prefilter_core #(
  parameter int unsigned QueueDepth = jsp_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           last_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o,
  output logic [2:0]                     fail_code_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jsp_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [jsp_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [jsp_pkg::DepthW-1:0] max_depth_q, max_depth_d;
  logic [jsp_pkg::SpanW-1:0]  max_span_q, max_span_d;

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  jsp_pkg::byte_class_t q_wdata;
  jsp_pkg::byte_class_t q_rdata;

  // Register writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    max_depth_d = max_depth_q;
    max_span_d  = max_span_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        jsp_pkg::CfgMaxDepth: max_depth_d = cfg_data_i[jsp_pkg::DepthW-1:0];
        jsp_pkg::CfgMaxSpan:  max_span_d  = cfg_data_i[jsp_pkg::SpanW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= jsp_pkg::MaxDepthRst;
      max_span_q  <= jsp_pkg::MaxSpanRst;
    end else begin
      max_depth_q <= max_depth_d;
      max_span_q  <= max_span_d;
    end
  end

  // The front end classifies each byte as it is transferred in.
  jsp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .ent_o       (q_wdata)
  );

  // The queue lets the scanner hold a last byte while the result is stalled.
  jsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // The scanner applies every rule and registers the verdict of each text.
  jsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_i       (q_rdata),
    .ent_pop_o   (q_pop),
    .max_depth_i (max_depth_q),
    .max_span_i  (max_span_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o),
    .fail_code_o (fail_code_o)
  );

endmodule

### sv/jsp_checker.sv
// Port-level checker for the JSON structure prefilter, bound to the top level.
// Depends on jsp_pkg and json_structure_prefilter_core_macros.svh.
`include "json_structure_prefilter_core_macros.svh"

module jsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       accepted_o,
  input logic [2:0] fail_code_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // A verdict is accept exactly when no failure code is given.
  `JSP_ASSERT_IMPL(a_accept_code, clk_i, rst_ni, out_valid_o, accepted_o == (fail_code_o == jsp_pkg::FailNone), "accepted and fail code disagree")

  // Only defined failure codes leave the block.
  `JSP_ASSERT_IMPL(a_code_range, clk_i, rst_ni, out_valid_o, fail_code_o <= jsp_pkg::FailClose, "undefined fail code")

  // A stalled result is held until its transfer.
  `JSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(accepted_o) && $stable(fail_code_o), "stalled result changed")

  // Register writes never wait.
  `JSP_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "configuration write refused")

endmodule

bind json_structure_prefilter_core jsp_checker u_jsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .accepted_o  (accepted_o),
  .fail_code_o (fail_code_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

### verif/tb_json_structure_prefilter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for json_structure_prefilter_core: directed probe texts, then
// random JSON-like texts under several limit settings. Depends on jsp_pkg and the core RTL.
module tb_json_structure_prefilter_core;
  import jsp_pkg::*;

  // An index past the two defined registers; the core must ignore writes to it.
  localparam logic [CfgIndexW-1:0] CfgUnusedIdx = 2'd3;
  localparam int unsigned NumProbes = 24;
  localparam int unsigned NumPhases = 7;
  localparam int unsigned BytesPerPhase = 160;
  localparam int unsigned HoldCycles = 300;

  // One verdict of the core: the fields of a result transfer.
  typedef struct packed {
    logic       acc;
    fail_code_e code;
  } verdict_t;

  // Shadow of the scanner state, kept by the predictor below.
  typedef struct packed {
    logic          in_str;
    logic          esc;
    logic [2:0]    nul_prog;
    logic [3:0]    depth;
    number_phase_e phase;
    logic          lead_zero;
    logic [4:0]    span;
    logic          failed;
    fail_code_e    first_fail;
  } scan_state_t;

  // A directed probe byte. The verdict fields only matter on a final byte.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       acc;
    fail_code_e code;
  } probe_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           text_byte_i;
  logic                 last_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 accepted_o;
  logic [2:0]           fail_code_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  // Predictor limits and scan state, plus the verdicts still owed by the core.
  logic [3:0]  lim_depth;
  logic [4:0]  lim_span;
  scan_state_t scan;
  verdict_t    verdicts_due[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned burst_left;
  logic        gaps_on;

  // Directed probes. Every verdict here can be read straight off the rules, so it is
  // typed in rather than taken from the predictor.
  probe_row_t probe_rows [NumProbes] = '{
    // A bare NUL byte.
    '{8'h00,    1'b1, 1'b0, FailNul},
    // A text that stops right after a backslash inside a string.
    '{ChQuote,  1'b0, 1'b0, FailNone},
    '{ChBslash, 1'b1, 1'b0, FailEscEnd},
    // A complete escaped u0000 inside a string.
    '{ChQuote,  1'b0, 1'b0, FailNone},
    '{ChBslash, 1'b0, 1'b0, FailNone},
    '{ChLowerU, 1'b0, 1'b0, FailNone},
    '{ChZero,   1'b0, 1'b0, FailNone},
    '{ChZero,   1'b0, 1'b0, FailNone},
    '{ChZero,   1'b0, 1'b0, FailNone},
    '{ChZero,   1'b1, 1'b0, FailEscNul},
    // A lone minus as the final byte.
    '{ChMinus,  1'b1, 1'b0, FailNumber},
    // A close with nothing open.
    '{ChRBrace, 1'b1, 1'b0, FailClose},
    // A leading zero followed by another digit.
    '{ChZero,   1'b0, 1'b0, FailNone},
    '{"1",      1'b1, 1'b0, FailNumber},
    // The top byte value is ordinary text.
    '{8'hFF,    1'b1, 1'b1, FailNone},
    // A negative number ended by the bracket that also closes its level.
    '{ChLBrack, 1'b0, 1'b0, FailNone},
    '{ChMinus,  1'b0, 1'b0, FailNone},
    '{"5",      1'b0, 1'b0, FailNone},
    '{ChRBrack, 1'b1, 1'b1, FailNone},
    // An escaped u0000 cut short by the end of the text passes.
    '{ChQuote,  1'b0, 1'b0, FailNone},
    '{ChBslash, 1'b0, 1'b0, FailNone},
    '{ChLowerU, 1'b0, 1'b0, FailNone},
    '{ChZero,   1'b0, 1'b0, FailNone},
    '{ChZero,   1'b1, 1'b1, FailNone}
  };

  json_structure_prefilter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o),
    .fail_code_o (fail_code_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the core hangs on either channel.
  initial begin
    #2_000_000;
    $display("[json_structure_prefilter_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the scanner. It follows the byte rules one accepted byte at a time.
  // ---------------------------------------------------------------------------

  // Only the first failing rule of a text is kept.
  function automatic void note_failure(fail_code_e code);
    if (!scan.failed) begin
      scan.failed     = 1'b1;
      scan.first_fail = code;
    end
  endfunction

  function automatic logic is_numeral(logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  // Whitespace from tab up to carriage return, space, comma and both closers.
  function automatic logic closes_number(logic [7:0] b);
    return ((b >= ChTab) && (b <= ChCr)) || (b == ChSpace) || (b == ChComma) ||
           (b == ChRBrack) || (b == ChRBrace);
  endfunction

  // One more character of a number, as long as the span limit allows it.
  function automatic void count_number_char();
    if (scan.span >= lim_span) begin
      note_failure(FailNumber);
    end else begin
      scan.span = scan.span + 5'd1;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    // The byte after a backslash is skipped; it only steers the u0000 matcher.
    if (scan.esc) begin
      scan.esc      = 1'b0;
      scan.nul_prog = (b == ChLowerU) ? NulAfterU : NulIdle;
      return;
    end
    // Count the zeros after an escaped u; the fourth one completes u0000.
    if (scan.nul_prog >= NulAfterU) begin
      if (b == ChZero) begin
        if (scan.nul_prog >= NulAllZero) begin
          note_failure(FailEscNul);
          return;
        end
        scan.nul_prog = scan.nul_prog + 3'd1;
      end else begin
        scan.nul_prog = NulIdle;
      end
    end
    // A minus must be followed by a digit.
    if (scan.phase == PhaseMinus) begin
      if (is_numeral(b)) begin
        scan.phase     = PhaseDigits;
        scan.lead_zero = (b == ChZero);
        count_number_char();
      end else begin
        note_failure(FailNumber);
      end
      return;
    end
    // Inside digits: more digits, or a terminator that then counts as an ordinary byte.
    if (scan.phase == PhaseDigits) begin
      if (is_numeral(b)) begin
        if (scan.lead_zero) begin
          note_failure(FailNumber);
        end else begin
          count_number_char();
        end
        return;
      end
      if (!closes_number(b)) begin
        note_failure(FailNumber);
        return;
      end
      scan.phase     = PhaseNone;
      scan.lead_zero = 1'b0;
      scan.span      = '0;
    end
    if (b == ChNul) begin
      note_failure(FailNul);
      return;
    end
    if (scan.in_str && (b == ChBslash)) begin
      scan.esc      = 1'b1;
      scan.nul_prog = NulBslash;
      return;
    end
    // A minus or a digit outside a string opens a number.
    if (!scan.in_str && ((b == ChMinus) || is_numeral(b))) begin
      scan.span = '0;
      if (b == ChMinus) begin
        scan.phase     = PhaseMinus;
        scan.lead_zero = 1'b0;
      end else begin
        scan.phase     = PhaseDigits;
        scan.lead_zero = (b == ChZero);
      end
      return;
    end
    if (b == ChQuote) begin
      scan.in_str = ~scan.in_str;
    end else if (!scan.in_str && ((b == ChLBrace) || (b == ChLBrack))) begin
      if (scan.depth >= lim_depth) begin
        note_failure(FailDepth);
      end else begin
        scan.depth = scan.depth + 4'd1;
      end
    end else if (!scan.in_str && ((b == ChRBrace) || (b == ChRBrack))) begin
      if (scan.depth == '0) begin
        note_failure(FailClose);
      end else begin
        scan.depth = scan.depth - 4'd1;
      end
    end
  endfunction

  // Advances the predictor by one accepted byte. Returns 1 when the byte ends the text,
  // with the verdict the core owes for it; the scan state then starts over.
  function automatic logic predict_byte(logic [7:0] b, logic fin, output verdict_t v);
    v = '0;
    if (!scan.failed) begin
      lex_byte(b);
    end
    if (!fin) begin
      return 1'b0;
    end
    // Rules that can only be judged once the text is over.
    if (!scan.failed) begin
      if (scan.esc) begin
        note_failure(FailEscEnd);
      end else if (scan.phase == PhaseMinus) begin
        note_failure(FailNumber);
      end
    end
    v.acc  = !scan.failed;
    v.code = scan.failed ? scan.first_fail : FailNone;
    scan   = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // Offers one byte and holds it until the core takes it. The sender works in bursts:
  // when a burst runs out and gaps are on, a gap may follow before the next one. Valid is
  // only lowered when a gap really follows, so it never drops and rises in one step.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input verdict_t typed_v);
    verdict_t    v;
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on && ($urandom_range(0, 1) == 0)) begin
        gap = $urandom_range(1, 5);
      end
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    last_byte_i <= fin;
    // Signals read right after the edge still hold their values from before it.
    do @(posedge clk_i); while (in_stall_o);
    if (predict_byte(b, fin, v)) begin
      verdicts_due.push_back(typed ? typed_v : v);
    end
  endtask

  // Writes one limit register and mirrors it in the predictor. Valid stays high across
  // back to back writes; the caller lowers it afterwards.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgMaxDepth: begin
        lim_depth = data[3:0];
      end
      CfgMaxSpan: begin
        lim_span = data;
      end
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [4:0] depth_data, input logic [4:0] span_data,
                            input logic poke_unused);
    write_reg(CfgMaxDepth, depth_data);
    write_reg(CfgMaxSpan, span_data);
    if (poke_unused) begin
      write_reg(CfgUnusedIdx, 5'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering bytes and lets the core drain: every owed verdict has to come out,
  // and then a further wait covers bytes still queued behind the last one.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Whitespace and comma for hi up to 6; 7 and 8 add the two closers.
  function automatic logic [7:0] pick_separator(int unsigned hi);
    case ($urandom_range(0, hi))
      0: return ChSpace;
      1: return ChTab;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      5: return ChCr;
      6: return ChComma;
      7: return ChRBrack;
      default: return ChRBrace;
    endcase
  endfunction

  // Builds one random text from JSON-like tokens: nesting, numbers near the span limit,
  // strings with escapes (u0000 among them), separators, words and some raw noise.
  // Now and then the text is made to end on a hazard such as a minus or a backslash.
  task automatic compose_text(ref logic [7:0] text[$]);
    int unsigned goal;
    int unsigned open_levels;
    int unsigned n;
    int unsigned k;
    logic [7:0]  c;
    text.delete();
    goal        = $urandom_range(1, 24);
    open_levels = 0;
    while (text.size() < goal) begin
      case ($urandom_range(0, 15))
        0, 1: begin
          text.push_back(($urandom_range(0, 1) == 0) ? ChLBrack : ChLBrace);
          open_levels++;
        end
        2, 3: begin
          if ((open_levels != 0) || ($urandom_range(0, 7) == 0)) begin
            text.push_back(($urandom_range(0, 1) == 0) ? ChRBrack : ChRBrace);
            if (open_levels != 0) begin
              open_levels--;
            end
          end
        end
        4, 5, 6: begin
          if ($urandom_range(0, 2) == 0) begin
            text.push_back(ChMinus);
          end
          n = $urandom_range(1, int'(lim_span) + 2);
          text.push_back(($urandom_range(0, 9) == 0) ? ChZero :
                         8'(ChZero + 8'($urandom_range(1, 9))));
          for (k = 1; k < n; k++) begin
            text.push_back(8'(ChZero + 8'($urandom_range(0, 9))));
          end
          // Mostly a proper terminator, sometimes any byte at all.
          if ($urandom_range(0, 7) == 0) begin
            text.push_back(8'($urandom_range(0, 255)));
          end else begin
            text.push_back(pick_separator(8));
          end
        end
        7, 8, 9: begin
          text.push_back(ChQuote);
          n = $urandom_range(0, 6);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
              text.push_back(ChBslash);
              case ($urandom_range(0, 4))
                0: begin
                  text.push_back(ChLowerU);
                  repeat ($urandom_range(0, 5)) text.push_back(ChZero);
                end
                1: text.push_back(ChQuote);
                2: text.push_back(ChBslash);
                3: text.push_back("n");
                default: text.push_back(8'($urandom_range(0, 255)));
              endcase
            end else begin
              c = 8'($urandom_range(32, 126));
              text.push_back(((c == ChQuote) || (c == ChBslash)) ? "a" : c);
            end
          end
          if ($urandom_range(0, 7) != 0) begin
            text.push_back(ChQuote);
          end
        end
        10, 11: begin
          text.push_back(pick_separator(6));
        end
        12: begin
          text.push_back(8'($urandom_range(0, 255)));
        end
        13: begin
          text.push_back(($urandom_range(0, 2) == 0) ? ChNul : ":");
        end
        default: begin
          text.push_back("t");
          text.push_back("r");
          text.push_back("u");
          text.push_back("e");
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: begin
        text.push_back(ChQuote);
        text.push_back(ChBslash);
      end
      1: text.push_back(ChMinus);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Receiver. Every result transfer is matched against the oldest owed verdict. The
  // stall follows modes of random length: never, light, heavy and alternating. Once,
  // after fifteen results, it stalls without a break while the sender keeps going,
  // so a final byte waits at the output, the queue fills and the input stalls.
  initial begin
    verdict_t    v;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    logic        hold_done;
    logic        stall_next;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          report_mismatch("result transfer with no verdict owed");
        end else begin
          v = verdicts_due.pop_front();
          if (accepted_o !== v.acc) begin
            report_mismatch($sformatf("accepted %b, predicted %b", accepted_o, v.acc));
          end
          if (fail_code_o !== v.code) begin
            report_mismatch($sformatf("fail code %0d, predicted %0d", fail_code_o, v.code));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (!hold_done && (results_seen >= 15)) begin
        hold_done  = 1'b1;
        hold_left  = HoldCycles - 1;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 2) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ~out_stall_i;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed probes at the reset limits, then random texts under
  // a series of limit settings, the extremes and out-of-range values among them.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  text[$];
    int unsigned sent;
    int unsigned phase;
    int unsigned i;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    text_byte_i  <= '0;
    last_byte_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    lim_depth    = MaxDepthRst;
    lim_span     = MaxSpanRst;
    scan         = '0;
    mismatches   = 0;
    results_seen = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumProbes; i++) begin
      send_byte(probe_rows[i].ch, probe_rows[i].fin, 1'b1,
                '{probe_rows[i].acc, probe_rows[i].code});
    end
    settle();

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        // Data bit 4 falls outside the depth register, so 31 gives the deepest setting.
        0: set_limits(5'd31, 5'd31, 1'b0);
        // A zero span turns any number longer than one character into a failure.
        1: set_limits(5'd1, 5'd0, 1'b1);
        // A zero depth turns any opening into a failure.
        2: set_limits(5'd0, 5'd1, 1'b0);
        3: set_limits(5'd2, 5'd3, 1'b1);
        default: set_limits(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                            1'($urandom_range(0, 1)));
      endcase
      sent = 0;
      while (sent < BytesPerPhase) begin
        compose_text(text);
        // Roughly one text in four runs with no gaps at all.
        gaps_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < text.size(); i++) begin
          send_byte(text[i], (i == text.size() - 1), 1'b0, '0);
        end
        sent += text.size();
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("[json_structure_prefilter_core] OK");
    end else begin
      $display("[json_structure_prefilter_core] ERROR");
    end
    $finish;
  end

endmodule
